@@ src/thr_pkg.sv @@
// thr_pkg: shared types and constants for the thick line rasterizer
// used by every module in src; depends on nothing
package thr_pkg;

  localparam int COORD_W  = 13;
  localparam int PIX_W    = 14;
  localparam int SPAN_W   = 14;
  localparam int ERR_W    = 16;
  localparam int SIDE_W   = 13;
  localparam int INDEX_W  = 24;
  localparam int COLOUR_W = 8;
  localparam int SIZE_W   = 3;
  localparam int IN_W     = 80;
  localparam int OUT_W    = 80;
  localparam int CFG_IDX_W = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_STEP = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_WIDTH  = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_HEIGHT = 8'd1;

  localparam logic [SIDE_W-1:0] RESET_FRAME_WIDTH  = 13'd640;
  localparam logic [SIDE_W-1:0] RESET_FRAME_HEIGHT = 13'd480;

  typedef enum logic {
    ST_IDLE,
    ST_DRAW
  } state_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] start_x;
    logic signed [COORD_W-1:0] start_y;
    logic signed [COORD_W-1:0] finish_x;
    logic signed [COORD_W-1:0] finish_y;
    logic [3*COLOUR_W-1:0]     colour;
  } load_t;

  typedef struct packed {
    logic load;
    logic advance;
    logic finish;
  } line_ctrl_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic [3*COLOUR_W-1:0]     colour;
    logic                      at_end;
    logic                      active;
  } line_status_t;

  typedef struct packed {
    logic signed [PIX_W-1:0] pixel_x;
    logic signed [PIX_W-1:0] pixel_y;
    logic [INDEX_W-1:0]      pixel_index;
    logic [COLOUR_W-1:0]     red;
    logic [COLOUR_W-1:0]     green;
    logic [COLOUR_W-1:0]     blue;
    logic                    write_enable;
    logic                    last_of_point;
    logic                    line_done;
  } pixel_t;

endpackage

@@ src/thr_line.sv @@
// thr_line: bresenham line state, load setup and per-point error update
// depends on thr_pkg
module thr_line #(
  parameter int HALF_W   = 2,
  parameter int SIZE_MAX = 7
) (
  input  logic                        clk,
  input  logic                        rst,
  input  thr_pkg::line_ctrl_t         ctrl,
  input  thr_pkg::load_t              load_data,
  input  logic [thr_pkg::SIZE_W-1:0]  brush_size,
  output thr_pkg::line_status_t       status,
  output logic [HALF_W-1:0]           half
);

  logic signed [thr_pkg::COORD_W-1:0] point_x, point_y, target_x, target_y;
  logic signed [thr_pkg::SPAN_W-1:0]  span_x, neg_span_y;
  logic signed [thr_pkg::ERR_W-1:0]   error_term, error_term_next;
  logic                               x_backward, y_backward, line_active;
  logic [3*thr_pkg::COLOUR_W-1:0]     line_colour;
  logic signed [thr_pkg::SPAN_W-1:0]  dx_raw, dy_raw, dx_abs, dy_abs;
  logic signed [thr_pkg::ERR_W:0]     e2;
  logic                               step_x, step_y;
  logic [thr_pkg::SIZE_W-1:0]         size_sat;

  assign dx_raw = thr_pkg::SPAN_W'(load_data.finish_x) - thr_pkg::SPAN_W'(load_data.start_x);
  assign dy_raw = thr_pkg::SPAN_W'(load_data.finish_y) - thr_pkg::SPAN_W'(load_data.start_y);
  assign dx_abs = dx_raw[thr_pkg::SPAN_W-1] ? -dx_raw : dx_raw;
  assign dy_abs = dy_raw[thr_pkg::SPAN_W-1] ? -dy_raw : dy_raw;
  assign size_sat = (brush_size > thr_pkg::SIZE_W'(SIZE_MAX)) ?
                    thr_pkg::SIZE_W'(SIZE_MAX) : brush_size;

  assign e2 = {error_term, 1'b0};
  assign step_x = e2 >= (thr_pkg::ERR_W+1)'(neg_span_y);
  assign step_y = e2 <= (thr_pkg::ERR_W+1)'(span_x);

  always_comb begin
    error_term_next = error_term;
    if (step_x) begin
      error_term_next = error_term_next + thr_pkg::ERR_W'(neg_span_y);
    end
    if (step_y) begin
      error_term_next = error_term_next + thr_pkg::ERR_W'(span_x);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      point_x     <= '0;
      point_y     <= '0;
      target_x    <= '0;
      target_y    <= '0;
      span_x      <= '0;
      neg_span_y  <= '0;
      x_backward  <= 1'b0;
      y_backward  <= 1'b0;
      error_term  <= '0;
      line_active <= 1'b0;
      line_colour <= '0;
      half        <= '0;
    end else if (ctrl.load) begin
      point_x     <= load_data.start_x;
      point_y     <= load_data.start_y;
      target_x    <= load_data.finish_x;
      target_y    <= load_data.finish_y;
      span_x      <= dx_abs;
      neg_span_y  <= -dy_abs;
      x_backward  <= !(load_data.start_x < load_data.finish_x);
      y_backward  <= !(load_data.start_y < load_data.finish_y);
      error_term  <= thr_pkg::ERR_W'(dx_abs) - thr_pkg::ERR_W'(dy_abs);
      line_colour <= load_data.colour;
      half        <= HALF_W'(size_sat >> 1);
      line_active <= 1'b1;
    end else if (ctrl.finish) begin
      line_active <= 1'b0;
    end else if (ctrl.advance) begin
      error_term <= error_term_next;
      if (step_x) begin
        point_x <= x_backward ? point_x - thr_pkg::COORD_W'(1) : point_x + thr_pkg::COORD_W'(1);
      end
      if (step_y) begin
        point_y <= y_backward ? point_y - thr_pkg::COORD_W'(1) : point_y + thr_pkg::COORD_W'(1);
      end
    end
  end

  assign status.point_x = point_x;
  assign status.point_y = point_y;
  assign status.colour  = line_colour;
  assign status.at_end  = (point_x == target_x) && (point_y == target_y);
  assign status.active  = line_active;

endmodule

@@ src/thr_pixel.sv @@
// thr_pixel: shared pixel unit, one brush pixel per use: coordinates, clip, address
// depends on thr_pkg
module thr_pixel #(
  parameter int HALF_W = 2,
  parameter int CNT_W  = 3
) (
  input  thr_pkg::line_status_t        status,
  input  logic [HALF_W-1:0]            half,
  input  logic [CNT_W-1:0]             col,
  input  logic [CNT_W-1:0]             row,
  input  logic                         last,
  input  logic [thr_pkg::SIDE_W-1:0]   width,
  input  logic [thr_pkg::SIDE_W-1:0]   height,
  output thr_pkg::pixel_t              pix
);

  logic signed [thr_pkg::PIX_W-1:0]  px, py;
  logic                              in_frame;
  logic [2*thr_pkg::SIDE_W-1:0]      product;
  logic [2*thr_pkg::SIDE_W-1:0]      address;

  assign px = thr_pkg::PIX_W'(status.point_x) + thr_pkg::PIX_W'(col) - thr_pkg::PIX_W'(half);
  assign py = thr_pkg::PIX_W'(status.point_y) + thr_pkg::PIX_W'(row) - thr_pkg::PIX_W'(half);

  assign in_frame = !px[thr_pkg::PIX_W-1] && !py[thr_pkg::PIX_W-1] &&
                    (px[thr_pkg::SIDE_W-1:0] < width) && (py[thr_pkg::SIDE_W-1:0] < height);

  assign product = py[thr_pkg::SIDE_W-1:0] * width;
  assign address = product + (2*thr_pkg::SIDE_W)'(px[thr_pkg::SIDE_W-1:0]);

  always_comb begin
    pix = '0;
    pix.last_of_point = 1'b1;
    pix.line_done     = 1'b1;
    if (status.active) begin
      pix.pixel_x       = px;
      pix.pixel_y       = py;
      pix.pixel_index   = in_frame ? address[thr_pkg::INDEX_W-1:0] : '0;
      pix.red           = status.colour[3*thr_pkg::COLOUR_W-1:2*thr_pkg::COLOUR_W];
      pix.green         = status.colour[2*thr_pkg::COLOUR_W-1:thr_pkg::COLOUR_W];
      pix.blue          = status.colour[thr_pkg::COLOUR_W-1:0];
      pix.write_enable  = in_frame;
      pix.last_of_point = last;
      pix.line_done     = last && status.at_end;
    end
  end

endmodule

@@ src/thick_line_rasterizer.sv @@
// thick_line_rasterizer: top level, sequencer, frame registers and output register
// depends on thr_pkg, thr_line, thr_pixel
//
// usage: items arrive on the s_ group; s_tuser is the kind (0 load, 1 step).
// a load transaction sets up a new line and produces nothing.
// a step transaction walks the square brush around the current point through the
// shared pixel unit, one brush pixel per cycle, x offset major, and sends each
// pixel on the m_ group; m_tlast marks the final pixel of the point and
// m_tuser carries write enable and line done.
// a step sends (2*(size/2)+1)^2 pixels (9 for a size-3 brush); the next item is
// accepted in the cycle of the final pixel.
// a step with no active line gives one result.
// the pixel unit and the single output register set the rate: when m_tready is
// low the output register holds and the brush walk waits.
// frame size is written on the cfg_ group, always ready; the user must write it
// only while the block idles, which it leaves unchecked. reset (rst, synchronous)
// drops any line and any pending result and restores frame size 640 x 480.
module thick_line_rasterizer #(
  parameter int MAX_BRUSH      = 7,
  parameter int MAX_FRAME_SIDE = 4096
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // start_x, start_y, finish_x, finish_y, red_in, green_in, blue_in, brush_size
  input  logic [thr_pkg::IN_W-1:0]        s_tdata,
  // kind
  input  logic                            s_tuser,
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // pixel_x, pixel_y, pixel_index, red_out, green_out, blue_out
  output logic [thr_pkg::OUT_W-1:0]       m_tdata,
  // write_enable, line_done
  output logic [1:0]                      m_tuser,
  output logic                            m_tlast,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [thr_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [thr_pkg::SIDE_W-1:0]      cfg_data
);

  localparam int HALF_MAX = MAX_BRUSH / 2;
  localparam int HALF_W   = (HALF_MAX > 0) ? $clog2(HALF_MAX + 1) : 1;
  localparam int CNT_W    = $clog2(2 * HALF_MAX + 2);
  localparam logic [thr_pkg::SIDE_W-1:0] SIDE_CAP = thr_pkg::SIDE_W'(MAX_FRAME_SIDE);

  thr_pkg::state_t        state, state_next;
  thr_pkg::line_ctrl_t    ctrl;
  thr_pkg::line_status_t  status;
  thr_pkg::load_t         load_data;
  thr_pkg::pixel_t        pix, out_pix;

  logic [thr_pkg::SIDE_W-1:0] frame_width, frame_height, width_cap, height_cap;
  logic [HALF_W-1:0]          half;
  logic [CNT_W-1:0]           col, row, side_last;
  logic                       out_free, emit, final_pix, last_emit, accept, step_accept;

  assign load_data.start_x  = s_tdata[12:0];
  assign load_data.start_y  = s_tdata[25:13];
  assign load_data.finish_x = s_tdata[38:26];
  assign load_data.finish_y = s_tdata[51:39];
  assign load_data.colour   = {s_tdata[59:52], s_tdata[67:60], s_tdata[75:68]};

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= thr_pkg::RESET_FRAME_WIDTH;
      frame_height <= thr_pkg::RESET_FRAME_HEIGHT;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        thr_pkg::REG_FRAME_WIDTH:  frame_width  <= cfg_data;
        thr_pkg::REG_FRAME_HEIGHT: frame_height <= cfg_data;
        default: ;
      endcase
    end
  end

  assign width_cap  = (frame_width  > SIDE_CAP) ? SIDE_CAP : frame_width;
  assign height_cap = (frame_height > SIDE_CAP) ? SIDE_CAP : frame_height;

  assign side_last = CNT_W'({half, 1'b0});
  assign out_free  = !m_tvalid || m_tready;
  assign emit      = (state == thr_pkg::ST_DRAW) && out_free;
  assign final_pix = !status.active || ((col == side_last) && (row == side_last));
  assign last_emit = emit && final_pix;
  assign accept    = s_tvalid && s_tready;
  assign step_accept = accept && (s_tuser == thr_pkg::KIND_STEP);

  always_comb begin
    state_next = state;
    case (state)
      thr_pkg::ST_IDLE: begin
        if (step_accept) state_next = thr_pkg::ST_DRAW;
      end
      thr_pkg::ST_DRAW: begin
        if (step_accept) state_next = thr_pkg::ST_DRAW;
        else if (last_emit) state_next = thr_pkg::ST_IDLE;
      end
      default: state_next = thr_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    s_tready = 1'b0;
    case (state)
      thr_pkg::ST_IDLE: s_tready = 1'b1;
      thr_pkg::ST_DRAW: s_tready = last_emit;
      default: s_tready = 1'b0;
    endcase
  end

  assign ctrl.load    = accept && (s_tuser == thr_pkg::KIND_LOAD);
  assign ctrl.advance = last_emit && status.active && !status.at_end;
  assign ctrl.finish  = last_emit && status.active && status.at_end;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= thr_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (step_accept) begin
      col <= '0;
      row <= '0;
    end else if (emit && !final_pix) begin
      if (row == side_last) begin
        row <= '0;
        col <= col + CNT_W'(1);
      end else begin
        row <= row + CNT_W'(1);
      end
    end
  end

  thr_line #(
    .HALF_W   (HALF_W),
    .SIZE_MAX (MAX_BRUSH)
  ) u_line (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (ctrl),
    .load_data  (load_data),
    .brush_size (s_tdata[78:76]),
    .status     (status),
    .half       (half)
  );

  thr_pixel #(
    .HALF_W (HALF_W),
    .CNT_W  (CNT_W)
  ) u_pixel (
    .status (status),
    .half   (half),
    .col    (col),
    .row    (row),
    .last   (final_pix),
    .width  (width_cap),
    .height (height_cap),
    .pix    (pix)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_pix <= pix;
    end
  end

  assign m_tdata = {4'b0, out_pix.blue, out_pix.green, out_pix.red, out_pix.pixel_index,
                    out_pix.pixel_y, out_pix.pixel_x};
  assign m_tuser = {out_pix.line_done, out_pix.write_enable};
  assign m_tlast = out_pix.last_of_point;

endmodule

@@ src/thr_checker.sv @@
// thr_checker: port-level checks on the thick line rasterizer output stream
// depends on thr_pkg; bound to thick_line_rasterizer below
module thr_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [thr_pkg::OUT_W-1:0]  m_tdata,
  input logic [1:0]                 m_tuser,
  input logic                       m_tlast
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("output changed while stalled");

  a_done_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[1] |-> m_tlast)
    else $error("line done without last of point");

  a_clip_index: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata[51:28] == 24'd0)
    else $error("index set on clipped pixel");

  a_inside_sign: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[0] |-> !m_tdata[13] && !m_tdata[27])
    else $error("write enable on negative coordinate");

  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("output valid right after reset");

endmodule

bind thick_line_rasterizer thr_checker u_thr_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

@@ tb/sv/thick_line_rasterizer_tb.sv @@
// thick_line_rasterizer_tb: self-checking bench for the thick line rasterizer
// drives load/step transactions and frame size writes, predicts every brush pixel
// depends on thr_pkg and thick_line_rasterizer
module thick_line_rasterizer_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int BRUSH_MAX      = 7;
  localparam int FRAME_SIDE_MAX = 4096;
  localparam int CYCLE_LIMIT    = 500000;
  localparam int SETTLE_CYCLES  = 16;
  localparam int HOLD_CYCLES    = 400;
  localparam int REPORT_CAP     = 100;

  localparam logic [thr_pkg::CFG_IDX_W-1:0] REG_SPARE = 8'd2;
  localparam logic [thr_pkg::CFG_IDX_W-1:0] REG_TOP   = 8'd255;

  typedef struct packed {
    logic                     kind;
    logic [thr_pkg::IN_W-1:0] data;
  } feed_item_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          s_tvalid = 1'b0;
  logic                          s_tready;
  logic [thr_pkg::IN_W-1:0]      s_tdata = '0;
  logic                          s_tuser = 1'b0;
  logic                          m_tvalid;
  logic                          m_tready = 1'b0;
  logic [thr_pkg::OUT_W-1:0]     m_tdata;
  logic [1:0]                    m_tuser;
  logic                          m_tlast;
  logic                          cfg_valid = 1'b0;
  logic                          cfg_ready;
  logic [thr_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [thr_pkg::SIDE_W-1:0]    cfg_data = '0;

  thick_line_rasterizer #(
    .MAX_BRUSH(BRUSH_MAX),
    .MAX_FRAME_SIDE(FRAME_SIDE_MAX)
  ) u_top (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),
    .s_tuser(s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),
    .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // predicted line state
  logic [thr_pkg::SIDE_W-1:0]         fb_width  = thr_pkg::RESET_FRAME_WIDTH;
  logic [thr_pkg::SIDE_W-1:0]         fb_height = thr_pkg::RESET_FRAME_HEIGHT;
  logic signed [thr_pkg::COORD_W-1:0] cur_x = '0, cur_y = '0, end_x = '0, end_y = '0;
  int                                 run_x = 0, neg_run_y = 0, bres_err = 0;
  logic                               step_back_x = 1'b0, step_back_y = 1'b0, drawing = 1'b0;
  logic [thr_pkg::COLOUR_W-1:0]       line_red = '0, line_green = '0, line_blue = '0;
  logic [1:0]                         half_side = '0;

  feed_item_t      feed_q[$];
  feed_item_t      next_item;
  thr_pkg::pixel_t pixels_due[$];
  thr_pkg::pixel_t got, want;
  int              mismatches = 0;
  int              pixels_seen = 0;
  int              cycle_count = 0;
  int              send_gap_pct = 19;
  int              recv_gap_pct = 84;
  bit              item_taken = 1'b0;
  bit              hold_go = 1'b0;
  bit              hold_on = 1'b0;

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int clip13(input int v);
    if (v > 4095) return 4095;
    if (v < -4096) return -4096;
    return v;
  endfunction

  function automatic void predict_pixels(input logic kind, input logic [thr_pkg::IN_W-1:0] d);
    int              sx, sy, fx, fy, sz, w, h, hs, tx, ty, px, py, e2;
    logic            on_end, in_frame, last;
    thr_pkg::pixel_t p;
    if (kind == thr_pkg::KIND_LOAD) begin
      sx = $signed(d[12:0]);
      sy = $signed(d[25:13]);
      fx = $signed(d[38:26]);
      fy = $signed(d[51:39]);
      sz = int'(d[78:76]);
      if (sz > BRUSH_MAX) sz = BRUSH_MAX;
      cur_x = thr_pkg::COORD_W'(sx);
      cur_y = thr_pkg::COORD_W'(sy);
      end_x = thr_pkg::COORD_W'(fx);
      end_y = thr_pkg::COORD_W'(fy);
      run_x = (fx > sx) ? fx - sx : sx - fx;
      neg_run_y = (fy > sy) ? sy - fy : fy - sy;
      step_back_x = !(sx < fx);
      step_back_y = !(sy < fy);
      bres_err = run_x + neg_run_y;
      line_red = d[59:52];
      line_green = d[67:60];
      line_blue = d[75:68];
      half_side = 2'(sz / 2);
      drawing = 1'b1;
      return;
    end
    p = '0;
    if (!drawing) begin
      p.last_of_point = 1'b1;
      p.line_done = 1'b1;
      pixels_due.push_back(p);
      return;
    end
    w = (fb_width > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : int'(fb_width);
    h = (fb_height > FRAME_SIDE_MAX) ? FRAME_SIDE_MAX : int'(fb_height);
    hs = int'(half_side);
    on_end = (cur_x == end_x) && (cur_y == end_y);
    for (tx = -hs; tx <= hs; tx++) begin
      for (ty = -hs; ty <= hs; ty++) begin
        px = cur_x + tx;
        py = cur_y + ty;
        in_frame = (px >= 0) && (py >= 0) && (px < w) && (py < h);
        last = (tx == hs) && (ty == hs);
        p.pixel_x = px[thr_pkg::PIX_W-1:0];
        p.pixel_y = py[thr_pkg::PIX_W-1:0];
        p.pixel_index = in_frame ? thr_pkg::INDEX_W'(py * w + px) : '0;
        p.red = line_red;
        p.green = line_green;
        p.blue = line_blue;
        p.write_enable = in_frame;
        p.last_of_point = last;
        p.line_done = last && on_end;
        pixels_due.push_back(p);
      end
    end
    if (on_end) begin
      drawing = 1'b0;
    end else begin
      e2 = 2 * bres_err;
      if (e2 >= neg_run_y) begin
        bres_err += neg_run_y;
        cur_x = thr_pkg::COORD_W'(cur_x + (step_back_x ? -1 : 1));
      end
      if (e2 <= run_x) begin
        bres_err += run_x;
        cur_y = thr_pkg::COORD_W'(cur_y + (step_back_y ? -1 : 1));
      end
    end
  endfunction

  task automatic report_mismatch(input string what, input longint actual, input longint wanted);
    mismatches++;
    if (mismatches <= REPORT_CAP)
      $display("pixel %0d: %s is %0d, expected %0d", pixels_seen, what, actual, wanted);
  endtask

  task automatic check_pixel(input thr_pkg::pixel_t a, input thr_pkg::pixel_t e);
    if (a.pixel_x != e.pixel_x) report_mismatch("pixel_x", a.pixel_x, e.pixel_x);
    if (a.pixel_y != e.pixel_y) report_mismatch("pixel_y", a.pixel_y, e.pixel_y);
    if (a.pixel_index != e.pixel_index)
      report_mismatch("pixel_index", a.pixel_index, e.pixel_index);
    if (a.red != e.red) report_mismatch("red", a.red, e.red);
    if (a.green != e.green) report_mismatch("green", a.green, e.green);
    if (a.blue != e.blue) report_mismatch("blue", a.blue, e.blue);
    if (a.write_enable != e.write_enable)
      report_mismatch("write_enable", a.write_enable, e.write_enable);
    if (a.last_of_point != e.last_of_point)
      report_mismatch("last_of_point", a.last_of_point, e.last_of_point);
    if (a.line_done != e.line_done) report_mismatch("line_done", a.line_done, e.line_done);
  endtask

  // monitor: output transactions first, then the input transaction of this edge
  always @(posedge clk) begin
    item_taken = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      got.pixel_x = m_tdata[13:0];
      got.pixel_y = m_tdata[27:14];
      got.pixel_index = m_tdata[51:28];
      got.red = m_tdata[59:52];
      got.green = m_tdata[67:60];
      got.blue = m_tdata[75:68];
      got.write_enable = m_tuser[0];
      got.line_done = m_tuser[1];
      got.last_of_point = m_tlast;
      if (pixels_due.size() == 0) begin
        report_mismatch("unexpected pixel, pending", 1, 0);
      end else begin
        want = pixels_due.pop_front();
        check_pixel(got, want);
      end
      pixels_seen++;
    end
    if (item_taken) predict_pixels(s_tuser, s_tdata);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || item_taken) begin
      if (feed_q.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
        next_item = feed_q.pop_front();
        s_tvalid <= 1'b1;
        s_tuser <= next_item.kind;
        s_tdata <= next_item.data;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    m_tready <= !rst && !hold_on && ($urandom_range(99) >= recv_gap_pct);
  end

  initial begin
    wait (hold_go);
    hold_on = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_on = 1'b0;
  end

  task automatic queue_load(input int sx, input int sy, input int fx, input int fy,
                            input int r, input int g, input int b, input int size);
    feed_item_t it;
    it.kind = thr_pkg::KIND_LOAD;
    it.data = {1'b0, size[2:0], b[7:0], g[7:0], r[7:0], fy[12:0], fx[12:0], sy[12:0],
               sx[12:0]};
    feed_q.push_back(it);
  endtask

  task automatic queue_steps(input int n);
    feed_item_t it;
    repeat (n) begin
      it.kind = thr_pkg::KIND_STEP;
      it.data = thr_pkg::IN_W'({$urandom, $urandom, $urandom});
      it.data[thr_pkg::IN_W-1] = 1'b0;
      feed_q.push_back(it);
    end
  endtask

  task automatic add_random_items(input int count);
    int added, pick, sx, sy, fx, fy, reach, lim_w, lim_h, len_x, len_y, n;
    added = 0;
    lim_w = (fb_width > 4090) ? 4090 : int'(fb_width);
    lim_h = (fb_height > 4090) ? 4090 : int'(fb_height);
    while (added < count) begin
      pick = $urandom_range(99);
      if (pick < 75) begin
        if ($urandom_range(3) == 0) begin
          sx = int'($urandom_range(8191)) - 4096;
          sy = int'($urandom_range(8191)) - 4096;
        end else begin
          sx = int'($urandom_range(lim_w + 8)) - 4;
          sy = int'($urandom_range(lim_h + 8)) - 4;
        end
        reach = ($urandom_range(7) == 0) ? 20 : 6;
        fx = clip13(sx + int'($urandom_range(2 * reach)) - reach);
        fy = clip13(sy + int'($urandom_range(2 * reach)) - reach);
        len_x = (fx > sx) ? fx - sx : sx - fx;
        len_y = (fy > sy) ? fy - sy : sy - fy;
        n = ((len_x > len_y) ? len_x : len_y) + 1 + (($urandom_range(3) == 0) ? 1 : 0);
        queue_load(sx, sy, fx, fy, $urandom_range(255), $urandom_range(255),
                   $urandom_range(255), $urandom_range(7));
        queue_steps(n);
        added += n + 1;
      end else if (pick < 90) begin
        n = $urandom_range(3);
        queue_load(int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
                   int'($urandom_range(8191)) - 4096, int'($urandom_range(8191)) - 4096,
                   $urandom_range(255), $urandom_range(255), $urandom_range(255),
                   $urandom_range(7));
        queue_steps(n);
        added += n + 1;
      end else begin
        queue_steps(1);
        added += 1;
      end
    end
  endtask

  task automatic write_frame_reg(input logic [thr_pkg::CFG_IDX_W-1:0] idx,
                                 input logic [thr_pkg::SIDE_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == thr_pkg::REG_FRAME_WIDTH) fb_width = val;
    else if (idx == thr_pkg::REG_FRAME_HEIGHT) fb_height = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_drained();
    while (feed_q.size() != 0 || s_tvalid || pixels_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int w, h, n;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // indexes past the register list must be ignored
    write_frame_reg(REG_SPARE, 13'd1234);
    write_frame_reg(REG_TOP, 13'h1fff);

    queue_steps(1);
    queue_load(0, 0, 3, 1, 255, 0, 0, 0);
    queue_steps(4);
    queue_load(0, 0, 0, 0, 8'h12, 8'h34, 8'h56, 7);
    queue_steps(1);
    queue_load(639, 479, 637, 477, 0, 255, 0, 5);
    queue_steps(3);
    queue_load(-4096, -4096, 4095, 4095, 255, 255, 255, 7);
    queue_steps(2);
    // replaces the active line
    queue_load(4095, -4096, -4096, 4095, 0, 0, 255, 4);
    queue_steps(2);
    queue_load(5, 5, 4, 9, 170, 85, 15, 3);
    queue_steps(6);
    wait_drained();

    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin w = 24;   h = 17;   n = 16; end
        1: begin w = 4096; h = 4096; n = 16; end
        2: begin w = 8191; h = 1;    n = 12; end
        3: begin w = 0;    h = 8191; n = 12; end
        default: begin w = 1; h = 4096; n = 12; end
      endcase
      write_frame_reg(thr_pkg::REG_FRAME_WIDTH, w[thr_pkg::SIDE_W-1:0]);
      write_frame_reg(thr_pkg::REG_FRAME_HEIGHT, h[thr_pkg::SIDE_W-1:0]);
      if (ph == 1) begin
        send_gap_pct = 84;
        recv_gap_pct = 19;
      end else if (ph == 3) begin
        send_gap_pct = 0;
        recv_gap_pct = 0;
      end
      add_random_items(n);
      if (ph == 3) hold_go = 1'b1;
      wait_drained();
    end

    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
